/* src/u8dec_pkg.sv */
// Shared types and constants for the UTF-8 to 16-bit code unit decoder.
package u8dec_pkg;

	localparam int unsigned ByteW = 8;
	localparam int unsigned UnitW = 16;
	localparam int unsigned StatW = 2;
	localparam int unsigned CntW  = 2;

	typedef enum logic [StatW-1:0] {
		ST_PENDING = 2'd0,
		ST_DONE    = 2'd1,
		ST_ERROR   = 2'd2
	} status_t;

	typedef struct packed {
		logic [UnitW-1:0] code_unit;
		status_t          status;
	} result_t;

endpackage

/* src/u8dec_in_stage.sv */
// Input register stage: holds one accepted byte until the decoder takes it.
module u8dec_in_stage
	import u8dec_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [ByteW-1:0] data_byte,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             advance,
	output logic             valid_s1,
	output logic [ByteW-1:0] byte_s1
);

	logic load;

	assign in_stall = valid_s1 && !advance;
	assign load     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_s1 <= data_byte;
		end
	end

endmodule

/* src/u8dec_decode.sv */
// Byte classifier with sequence state: continuation count and partial code unit.
module u8dec_decode
	import u8dec_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  logic [ByteW-1:0] byte_s1,
	output result_t          res
);

	logic [CntW-1:0]  remain_q, remain_d;
	logic [UnitW-1:0] partial_q, partial_d;
	logic [UnitW-1:0] shifted;
	logic             is_cont;

	assign is_cont = (byte_s1[7:6] == 2'b10);
	assign shifted = {partial_q[UnitW-7:0], byte_s1[5:0]};

	always_comb begin
		remain_d      = remain_q;
		partial_d     = partial_q;
		res.code_unit = '0;
		res.status    = ST_ERROR;
		if (remain_q != '0) begin
			if (!is_cont) begin
				remain_d  = '0;
				partial_d = '0;
			end else if (remain_q == CntW'(1)) begin
				remain_d      = '0;
				partial_d     = '0;
				res.code_unit = shifted;
				res.status    = ST_DONE;
			end else begin
				remain_d   = remain_q - CntW'(1);
				partial_d  = shifted;
				res.status = ST_PENDING;
			end
		end else begin
			priority casez (byte_s1)
				8'b0???????: begin
					res.code_unit = {{(UnitW-ByteW){1'b0}}, byte_s1};
					res.status    = ST_DONE;
				end
				8'b110?????: begin
					partial_d  = {{(UnitW-5){1'b0}}, byte_s1[4:0]};
					remain_d   = CntW'(1);
					res.status = ST_PENDING;
				end
				8'b1110????: begin
					partial_d  = {{(UnitW-4){1'b0}}, byte_s1[3:0]};
					remain_d   = CntW'(2);
					res.status = ST_PENDING;
				end
				default: begin
					res.status = ST_ERROR;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remain_q  <= '0;
			partial_q <= '0;
		end else if (advance) begin
			remain_q  <= remain_d;
			partial_q <= partial_d;
		end
	end

endmodule

/* src/u8dec_out_stage.sv */
// Result register: holds one result until the downstream side takes it.
module u8dec_out_stage
	import u8dec_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid_s1,
	input  result_t          res,
	output logic             advance,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [UnitW-1:0] code_unit,
	output logic [StatW-1:0] status
);

	result_t res_q;

	assign advance   = valid_s1 && (!out_valid || !out_stall);
	assign code_unit = res_q.code_unit;
	assign status    = res_q.status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (!out_valid || !out_stall) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

endmodule

/* src/utf8_to_utf16_unit_decoder_unit.sv */
// Top level of the UTF-8 to 16-bit code unit decoder.
// Takes one UTF-8 byte per transfer and returns one result per byte: status
// 0 (more bytes pending), 1 (code_unit holds a completed character) or 2
// (error: stray continuation, 0xFE/0xFF, four- to six-byte lead, or a broken
// sequence, whose offending byte is dropped). Overlong forms decode normally.
// code_unit is zero unless status is 1. A byte is accepted every cycle while in_stall
// is low. The byte sits in the input register, the single decode step runs, and the
// result register captures the result when it is free. A stalled result holds the
// result register; a byte in the input register is then held and stalls the input.
module utf8_to_utf16_unit_decoder_unit
	import u8dec_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [ByteW-1:0] data_byte,
	input  logic             in_valid,
	output logic             in_stall,
	output logic [UnitW-1:0] code_unit,
	output logic [StatW-1:0] status,
	output logic             out_valid,
	input  logic             out_stall
);

	logic             advance;
	logic             valid_s1;
	logic [ByteW-1:0] byte_s1;
	result_t          res;

	u8dec_in_stage u_in (
		.clk       (clk),
		.arst_n    (arst_n),
		.data_byte (data_byte),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.advance   (advance),
		.valid_s1  (valid_s1),
		.byte_s1   (byte_s1)
	);

	u8dec_decode u_dec (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.byte_s1 (byte_s1),
		.res     (res)
	);

	u8dec_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.res       (res),
		.advance   (advance),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.code_unit (code_unit),
		.status    (status)
	);

	a_unit_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_DONE) |-> code_unit == '0)
		else $error("code_unit nonzero without completed character");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid && out_stall)
		else $error("input stalled while pipeline can move");

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall
			|=> out_valid && $stable(code_unit) && $stable(status))
		else $error("stalled result changed");

endmodule

/* verif/tb_utf8_to_utf16_unit_decoder_unit.sv */
`timescale 1ns / 100ps
// Testbench for the UTF-8 to 16-bit code unit decoder: directed and random byte streams.
module tb_utf8_to_utf16_unit_decoder_unit;
	import u8dec_pkg::*;

	localparam int QuietLimit = 2000;
	localparam int DrainCycles = 8;
	localparam logic [1:0] ContTag = 2'b10;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic [ByteW-1:0] data_byte = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [UnitW-1:0] code_unit;
	logic [StatW-1:0] status;
	logic out_valid;
	logic out_stall = 1'b0;

	logic [CntW-1:0] cont_left = '0;
	logic [UnitW-1:0] acc_unit = '0;
	result_t pending_units[$];
	int bytes_sent = 0;
	int err_cnt = 0;
	int stall_left = 0;
	int quiet_cycles = 0;
	bit idle_en = 1'b0;

	utf8_to_utf16_unit_decoder_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.data_byte (data_byte),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.code_unit (code_unit),
		.status    (status),
		.out_valid (out_valid),
		.out_stall (out_stall)
	);

	always #2 clk = ~clk;

	function automatic result_t decode_byte(input logic [ByteW-1:0] b);
		result_t r;
		r.code_unit = '0;
		r.status = ST_ERROR;
		if (cont_left != 0) begin
			if (b[7:6] != ContTag) begin
				cont_left = '0;
				acc_unit = '0;
			end else begin
				acc_unit = {acc_unit[UnitW-7:0], b[5:0]};
				cont_left = cont_left - 1'b1;
				if (cont_left == 0) begin
					r.code_unit = acc_unit;
					r.status = ST_DONE;
					acc_unit = '0;
				end else begin
					r.status = ST_PENDING;
				end
			end
		end else if (!b[7]) begin
			r.code_unit = {8'h00, b};
			r.status = ST_DONE;
		end else if (!b[6]) begin
			r.status = ST_ERROR;
		end else if (!b[5]) begin
			acc_unit = {11'b0, b[4:0]};
			cont_left = 2'd1;
			r.status = ST_PENDING;
		end else if (!b[4]) begin
			acc_unit = {12'b0, b[3:0]};
			cont_left = 2'd2;
			r.status = ST_PENDING;
		end
		return r;
	endfunction

	function automatic logic [ByteW-1:0] cont_byte();
		return {ContTag, 6'($urandom_range(0, 63))};
	endfunction

	function automatic logic [ByteW-1:0] non_cont_byte();
		logic [ByteW-1:0] b;
		do
			b = 8'($urandom);
		while (b[7:6] == ContTag);
		return b;
	endfunction

	task automatic send_byte(input logic [ByteW-1:0] b);
		if (idle_en && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		do
			@(posedge clk);
		while (in_stall);
		pending_units.push_back(decode_byte(b));
		bytes_sent++;
	endtask

	// result checker
	always @(posedge clk) begin
		result_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_units.size() == 0) begin
				$display("%0t: unexpected transfer code_unit %h status %0d", $time, code_unit,
					status);
				err_cnt++;
			end else begin
				exp_r = pending_units.pop_front();
				if (code_unit !== exp_r.code_unit) begin
					$display("%0t: code_unit expected %h actual %h", $time, exp_r.code_unit,
						code_unit);
					err_cnt++;
				end
				if (status !== exp_r.status) begin
					$display("%0t: status expected %0d actual %0d", $time, exp_r.status, status);
					err_cnt++;
				end
			end
		end
	end

	// receiver stalls
	always @(posedge clk) begin
		if (stall_left == 0 && idle_en && $urandom_range(0, 7) == 0)
			stall_left = $urandom_range(1, 12);
		out_stall <= (stall_left != 0);
		if (stall_left != 0)
			stall_left--;
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QuietLimit) begin
			$display("tb_utf8_to_utf16_unit_decoder_unit: errors");
			$finish;
		end
	end

	task automatic test_single_byte();
		send_byte(8'h00);
		send_byte(8'h7F);
	endtask

	task automatic test_two_byte();
		send_byte(8'hC2); send_byte(8'hA9);
		send_byte(8'hDF); send_byte(8'hBF);
		// overlong NUL
		send_byte(8'hC0); send_byte(8'h80);
	endtask

	task automatic test_three_byte();
		send_byte(8'hEF); send_byte(8'hBF); send_byte(8'hBF);
		send_byte(8'hE0); send_byte(8'h80); send_byte(8'h80);
	endtask

	task automatic test_bad_bytes();
		send_byte(8'h80);
		send_byte(8'hF0);
		send_byte(8'hF8);
		send_byte(8'hFC);
		send_byte(8'hFE);
		send_byte(8'hFF);
	endtask

	task automatic test_broken_sequence();
		send_byte(8'hC3); send_byte(8'h41);
		// dropped lead mid-sequence
		send_byte(8'hE2); send_byte(8'h82); send_byte(8'hC3);
	endtask

	task automatic test_random_stream(input int count);
		int target;
		int kind;
		int leads;
		target = bytes_sent + count;
		while (bytes_sent < target) begin
			kind = $urandom_range(0, 19);
			if (kind < 5) begin
				send_byte(8'($urandom_range(0, 8'h7F)));
			end else if (kind < 9) begin
				send_byte(8'hC0 | 8'($urandom_range(0, 31)));
				send_byte(cont_byte());
			end else if (kind < 13) begin
				send_byte(8'hE0 | 8'($urandom_range(0, 15)));
				send_byte(cont_byte());
				send_byte(cont_byte());
			end else if (kind < 15) begin
				leads = $urandom_range(1, 2);
				if (leads == 1)
					send_byte(8'hC0 | 8'($urandom_range(0, 31)));
				else
					send_byte(8'hE0 | 8'($urandom_range(0, 15)));
				repeat ($urandom_range(0, leads - 1)) send_byte(cont_byte());
				send_byte(non_cont_byte());
			end else if (kind < 17) begin
				send_byte(cont_byte());
			end else if (kind < 18) begin
				send_byte(8'hF0 | 8'($urandom_range(0, 15)));
			end else begin
				send_byte(8'($urandom));
			end
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		idle_en = 1'b1;
		test_single_byte();
		test_two_byte();
		test_three_byte();
		test_bad_bytes();
		test_broken_sequence();
		test_random_stream(500);
		idle_en = 1'b0;
		test_random_stream(250);
		in_valid <= 1'b0;
		while (pending_units.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (err_cnt == 0)
			$display("tb_utf8_to_utf16_unit_decoder_unit: clean");
		else
			$display("tb_utf8_to_utf16_unit_decoder_unit: errors");
		$finish;
	end

endmodule

/* filelist.f */
src/u8dec_pkg.sv
src/u8dec_in_stage.sv
src/u8dec_decode.sv
src/u8dec_out_stage.sv
src/utf8_to_utf16_unit_decoder_unit.sv
verif/tb_utf8_to_utf16_unit_decoder_unit.sv
